### rtl/masi_pkg.sv
// Shared types and constants of the multi-axis step interpolator.
// No dependencies; every rtl module imports this package.
package masi_pkg;

	localparam int AXES      = 6;
	localparam int POS_BITS  = 24;
	localparam int MAG_BITS  = POS_BITS + 1;
	localparam int HALF_BITS = 16;
	localparam int TICK_BITS = HALF_BITS + 1;

	localparam logic [HALF_BITS-1:0] HALF_PERIOD_RESET = HALF_BITS'(100);

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// register map
	localparam int                PADDR_BITS         = 3;
	localparam logic [PADDR_BITS-1:0] REG_HALF_PERIOD_ADDR = '0;

	typedef struct packed {
		logic                             is_load;
		logic [AXES-1:0][POS_BITS-1:0]    goal;
	} item_t;

	typedef struct packed {
		logic [AXES-1:0] step_lines;
		logic [AXES-1:0] dir_lines;
		logic            busy_res;
		logic            arrived;
		logic            load_rejected;
	} result_t;

endpackage

### rtl/masi_front.sv
// Front end: takes input transfers, decodes the opcode and packs the goals.
// Depends on masi_pkg.
module masi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a0,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a1,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a2,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a3,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a4,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a5,
	output logic                          push_valid,
	input  logic                          push_full,
	output masi_pkg::item_t               push_item
);
	import masi_pkg::*;

	logic                 valid_s1;
	item_t                item_s1;
	item_t                item_d;
	logic [POS_BITS-1:0]  goal_port [6];
	logic                 take;

	assign goal_port[0] = goal_a0;
	assign goal_port[1] = goal_a1;
	assign goal_port[2] = goal_a2;
	assign goal_port[3] = goal_a3;
	assign goal_port[4] = goal_a4;
	assign goal_port[5] = goal_a5;

	// decode: a tick carries no goals, so clear them
	always_comb begin
		item_d.is_load = (opcode == OP_LOAD);
		for (int k = 0; k < AXES; k++) begin
			item_d.goal[k] = (opcode == OP_LOAD) ? goal_port[k] : '0;
		end
	end

	assign in_stall   = valid_s1 & push_full;
	assign take       = in_valid & ~in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

### rtl/masi_queue.sv
// Two-entry queue between front end and stepping engine.
// Depends on masi_pkg.
module masi_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            full,
	input  masi_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_en,
	output masi_pkg::item_t rd_item
);
	import masi_pkg::*;

	localparam int DEPTH = 2;

	item_t                     mem [DEPTH];
	logic [$clog2(DEPTH)-1:0]  wr_ptr_q;
	logic [$clog2(DEPTH)-1:0]  rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;
	logic                      push;
	logic                      pop;

	assign full     = (count_q == ($clog2(DEPTH+1))'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid & ~full;
	assign pop      = rd_en & rd_valid;
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### rtl/masi_back.sv
// Stepping engine: runs loads and ticks, keeps axis state, drives results.
// Depends on masi_pkg.
module masi_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [masi_pkg::HALF_BITS-1:0]    half_period,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  masi_pkg::item_t                   q_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output masi_pkg::result_t                 res
);
	import masi_pkg::*;

	logic signed [POS_BITS-1:0] pos_q   [AXES];
	logic signed [POS_BITS-1:0] goal_q  [AXES];
	logic [MAG_BITS-1:0]        mag_q   [AXES];
	logic [MAG_BITS-1:0]        acc_q   [AXES];
	logic [AXES-1:0]            dir_q;
	logic [MAG_BITS-1:0]        major_q;
	logic [MAG_BITS-1:0]        idx_q;
	logic [TICK_BITS-1:0]       tick_q;
	logic                       moving_q;

	logic signed [POS_BITS-1:0] pos_n   [AXES];
	logic signed [POS_BITS-1:0] goal_n  [AXES];
	logic [MAG_BITS-1:0]        mag_n   [AXES];
	logic [MAG_BITS-1:0]        acc_n   [AXES];
	logic [AXES-1:0]            dir_n;
	logic [MAG_BITS-1:0]        major_n;
	logic [MAG_BITS-1:0]        idx_n;
	logic [TICK_BITS-1:0]       tick_n;
	logic                       moving_n;

	logic signed [MAG_BITS-1:0] delta_w [AXES];
	logic [MAG_BITS-1:0]        absd_w  [AXES];
	logic [MAG_BITS:0]          sum_w   [AXES];
	logic [AXES-1:0]            hit_w;
	logic [MAG_BITS-1:0]        max_w;
	logic [MAG_BITS-1:0]        idx_inc;
	logic [HALF_BITS-1:0]       half;
	logic [TICK_BITS-1:0]       last_tick;
	logic [AXES-1:0]            steps;
	logic                       rejected;
	logic                       at_goal;

	assign half      = (half_period == '0) ? HALF_BITS'(1) : half_period;
	assign last_tick = {half, 1'b0} - TICK_BITS'(1);
	assign idx_inc   = idx_q + MAG_BITS'(1);
	assign q_pop     = q_valid & (~out_valid | ~out_stall);

	// per-axis delta on load, accumulator test on tick
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			delta_w[k] = MAG_BITS'(signed'(q_item.goal[k])) - MAG_BITS'(pos_q[k]);
			absd_w[k]  = delta_w[k][MAG_BITS-1] ? MAG_BITS'(-delta_w[k])
			                                    : MAG_BITS'(delta_w[k]);
			sum_w[k]   = {1'b0, acc_q[k]} + {1'b0, mag_q[k]};
			hit_w[k]   = (sum_w[k] >= {1'b0, major_q});
		end
	end

	// running maximum of the load magnitudes
	always_comb begin
		max_w = '0;
		for (int k = 0; k < AXES; k++) begin
			if (absd_w[k] > max_w) max_w = absd_w[k];
		end
	end

	always_comb begin
		pos_n    = pos_q;
		goal_n   = goal_q;
		mag_n    = mag_q;
		acc_n    = acc_q;
		dir_n    = dir_q;
		major_n  = major_q;
		idx_n    = idx_q;
		tick_n   = tick_q;
		moving_n = moving_q;
		steps    = '0;
		rejected = 1'b0;
		if (q_item.is_load) begin
			if (moving_q) begin
				rejected = 1'b1;
			end else begin
				for (int k = 0; k < AXES; k++) begin
					goal_n[k] = q_item.goal[k];
					dir_n[k]  = ~delta_w[k][MAG_BITS-1] & (delta_w[k] != '0);
					mag_n[k]  = absd_w[k];
					acc_n[k]  = '0;
				end
				major_n  = max_w;
				idx_n    = '0;
				tick_n   = '0;
				moving_n = (max_w != '0);
			end
		end else if (moving_q) begin
			if (tick_q < {1'b0, half}) steps = hit_w;
			if (tick_q >= last_tick) begin
				// end of the interpolation step: commit accumulators and positions
				for (int k = 0; k < AXES; k++) begin
					if (hit_w[k]) begin
						acc_n[k] = MAG_BITS'(sum_w[k] - {1'b0, major_q});
						pos_n[k] = dir_q[k] ? pos_q[k] + POS_BITS'(1)
						                    : pos_q[k] - POS_BITS'(1);
					end else begin
						acc_n[k] = MAG_BITS'(sum_w[k]);
					end
				end
				idx_n  = idx_inc;
				tick_n = '0;
				if (idx_inc >= major_q) moving_n = 1'b0;
			end else begin
				tick_n = tick_q + TICK_BITS'(1);
			end
		end
	end

	always_comb begin
		at_goal = 1'b1;
		for (int k = 0; k < AXES; k++) begin
			if (pos_n[k] != goal_n[k]) at_goal = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) begin
				pos_q[k]  <= '0;
				goal_q[k] <= '0;
				mag_q[k]  <= '0;
				acc_q[k]  <= '0;
			end
			dir_q     <= '0;
			major_q   <= '0;
			idx_q     <= '0;
			tick_q    <= '0;
			moving_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				pos_q    <= pos_n;
				goal_q   <= goal_n;
				mag_q    <= mag_n;
				acc_q    <= acc_n;
				dir_q    <= dir_n;
				major_q  <= major_n;
				idx_q    <= idx_n;
				tick_q   <= tick_n;
				moving_q <= moving_n;
			end
			if (q_pop) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res.step_lines    <= steps;
			res.dir_lines     <= dir_n;
			res.busy_res      <= moving_n;
			res.arrived       <= at_goal;
			res.load_rejected <= rejected;
		end
	end

endmodule

### rtl/multi_axis_step_interpolator.sv
// Multi-axis straight-line step interpolator, top level.
// Path: an input transfer passes the front-end register, the queue and the output register.
// Throughput: one transfer per cycle while the output is not stalled, set by the stepping engine.
// Reset: positions, goals and move state clear to zero and idle,
// half period returns to 100; no clearing pass, ready at once.
module multi_axis_step_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [masi_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a0,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a1,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a2,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a3,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a4,
	input  logic signed [masi_pkg::POS_BITS-1:0] goal_a5,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [masi_pkg::AXES-1:0]            step_lines,
	output logic [masi_pkg::AXES-1:0]            dir_lines,
	output logic                                 busy_res,
	output logic                                 arrived,
	output logic                                 load_rejected
);
	import masi_pkg::*;

	logic [HALF_BITS-1:0] half_period_q;
	logic                 push_valid;
	logic                 push_full;
	item_t                push_item;
	logic                 q_valid;
	logic                 q_pop;
	item_t                q_item;
	result_t              res;

	// Configuration: the half period register accepts a write transfer
	// in the access phase; reads return it zero-extended.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr == REG_HALF_PERIOD_ADDR) begin
			half_period_q <= pwdata[HALF_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_HALF_PERIOD_ADDR) prdata = 32'(half_period_q);
	end

	// Front end: register the incoming transfer and tag loads vs ticks.
	masi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.goal_a0    (goal_a0),
		.goal_a1    (goal_a1),
		.goal_a2    (goal_a2),
		.goal_a3    (goal_a3),
		.goal_a4    (goal_a4),
		.goal_a5    (goal_a5),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_item  (push_item)
	);

	// Queue: decouples the front end from output back-pressure.
	masi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.full     (push_full),
		.wr_item  (push_item),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_item  (q_item)
	);

	// Back end: one item per cycle into the stepping state while the output is not stalled, result
	// held in an output register until the consumer takes it.
	masi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res)
	);

	assign step_lines    = res.step_lines;
	assign dir_lines     = res.dir_lines;
	assign busy_res      = res.busy_res;
	assign arrived       = res.arrived;
	assign load_rejected = res.load_rejected;

endmodule
